/* src/vdts_pkg.sv */
// ----------------------------------------------------------------------------
// vdts_pkg: shared types and constants of the value density task scheduler
// Holds the table size, field widths, command codes and sequencer states.
// ----------------------------------------------------------------------------
package vdts_pkg;

	// Table geometry and field widths.
	localparam int NUM_TASKS = 8;
	localparam int SLOT_W    = 3;
	localparam int RSLOT_W   = 4;
	localparam int FIELD_W   = 16;
	localparam int TICK_W    = 32;

	// Slot code reported when nothing runs.
	localparam logic [RSLOT_W-1:0] IDLE_SLOT = 4'd8;

	// Input item kinds.
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN_A,
		ST_SCAN_B,
		ST_EXEC,
		ST_RELEASE,
		ST_FINISH
	} state_t;

endpackage

/* src/vdts_if.sv */
// ----------------------------------------------------------------------------
// vdts channel interfaces
// Valid/ready channels for the task items and the scheduling results.
// ----------------------------------------------------------------------------
interface vdts_req_if;
	logic                          valid;
	logic                          ready;
	logic                          kind;
	logic [vdts_pkg::SLOT_W-1:0]   slot;
	logic [vdts_pkg::FIELD_W-1:0]  task_period;
	logic [vdts_pkg::FIELD_W-1:0]  task_capacity;
	logic [vdts_pkg::FIELD_W-1:0]  task_value;

	modport source (output valid, kind, slot, task_period, task_capacity, task_value,
		input ready);
	modport sink (input valid, kind, slot, task_period, task_capacity, task_value,
		output ready);
endinterface

interface vdts_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [vdts_pkg::RSLOT_W-1:0]  running_slot;
	logic                          idle;
	logic                          job_finished;
	logic [vdts_pkg::TICK_W-1:0]   tick_now;

	modport source (output valid, running_slot, idle, job_finished, tick_now,
		input ready);
	modport sink (input valid, running_slot, idle, job_finished, tick_now,
		output ready);
endinterface

/* src/value_density_task_scheduler_core.sv */
// ----------------------------------------------------------------------------
// value_density_task_scheduler_core: highest value density first scheduler
// Periodic task table with one shared 16x16 multiplier under a sequencer.
// ----------------------------------------------------------------------------
// A load transaction writes one of eight task slots and produces no result. A
// tick transaction walks the slots one at a time: each slot gets a scan step,
// plus a second one when it is pending and a best candidate already exists,
// since both cross products go through the one multiplier. When a task runs,
// an execution bookkeeping step follows, then a release product step for a
// completed job, and a finish step loads the output register once it is free.
// The block is not ready while it works, but a finished result may wait in the
// output register while the next transaction is taken.
module value_density_task_scheduler_core (
	input  logic         clk,
	input  logic         arst_n,
	vdts_req_if.sink     req,
	vdts_rsp_if.source   rsp
);

	localparam int SW = vdts_pkg::SLOT_W;
	localparam int FW = vdts_pkg::FIELD_W;
	localparam int TW = vdts_pkg::TICK_W;

	// Task table.
	logic [vdts_pkg::NUM_TASKS-1:0] valid_q;
	logic [vdts_pkg::NUM_TASKS-1:0] pending_q;
	logic [FW-1:0] period_q   [vdts_pkg::NUM_TASKS];
	logic [FW-1:0] capacity_q [vdts_pkg::NUM_TASKS];
	logic [FW-1:0] value_q    [vdts_pkg::NUM_TASKS];
	logic [FW-1:0] executed_q [vdts_pkg::NUM_TASKS];
	logic [FW-1:0] jobs_q     [vdts_pkg::NUM_TASKS];
	logic [TW-1:0] release_q  [vdts_pkg::NUM_TASKS];
	logic [TW-1:0] tick_count_q;

	// Sequencer and scan state.
	vdts_pkg::state_t state_q, state_d;
	logic [SW-1:0] idx_q;
	logic [SW-1:0] best_q;
	logic          found_q;
	logic          finished_q;
	logic [FW-1:0] best_val_q;
	logic [FW-1:0] best_cap_q;
	logic [TW-1:0] prod_q;

	// Output register.
	logic                          out_valid_q;
	logic [vdts_pkg::RSLOT_W-1:0]  out_slot_q;
	logic                          out_idle_q;
	logic                          out_fin_q;
	logic [TW-1:0]                 out_tick_q;

	// Combinational helpers.
	logic          accept;
	logic          tick_start;
	logic          load_now;
	logic          eff_pend;
	logic          scan_last;
	logic [FW-1:0] exe_inc;
	logic          exe_done;
	logic [FW-1:0] mul_a;
	logic [FW-1:0] mul_b;
	logic [TW-1:0] mul_p;
	logic          out_load;

	assign accept     = req.valid && req.ready;
	assign tick_start = accept && (req.kind == vdts_pkg::KIND_TICK);
	assign load_now   = accept && (req.kind == vdts_pkg::KIND_LOAD);
	assign req.ready  = (state_q == vdts_pkg::ST_IDLE);

	// A slot is pending if already so or if its release falls on this tick.
	assign eff_pend  = valid_q[idx_q] &&
		(pending_q[idx_q] || (release_q[idx_q] == tick_count_q));
	assign scan_last = (idx_q == SW'(vdts_pkg::NUM_TASKS - 1));
	assign exe_inc   = executed_q[best_q] + FW'(1);
	assign exe_done  = (exe_inc >= capacity_q[best_q]);
	assign out_load  = (state_q == vdts_pkg::ST_FINISH) && (!out_valid_q || rsp.ready);

	// Shared multiplier operand selection.
	always_comb begin
		case (state_q)
			vdts_pkg::ST_SCAN_A: begin
				mul_a = value_q[idx_q];
				mul_b = best_cap_q;
			end
			vdts_pkg::ST_SCAN_B: begin
				mul_a = best_val_q;
				mul_b = capacity_q[idx_q];
			end
			vdts_pkg::ST_RELEASE: begin
				mul_a = period_q[best_q];
				mul_b = jobs_q[best_q];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = {16'd0, mul_a} * {16'd0, mul_b};

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			vdts_pkg::ST_IDLE: begin
				if (tick_start) state_d = vdts_pkg::ST_SCAN_A;
			end
			vdts_pkg::ST_SCAN_A: begin
				if (eff_pend && found_q) begin
					state_d = vdts_pkg::ST_SCAN_B;
				end else if (scan_last) begin
					state_d = (found_q || eff_pend) ? vdts_pkg::ST_EXEC
						: vdts_pkg::ST_FINISH;
				end
			end
			vdts_pkg::ST_SCAN_B: begin
				if (scan_last) state_d = vdts_pkg::ST_EXEC;
				else state_d = vdts_pkg::ST_SCAN_A;
			end
			vdts_pkg::ST_EXEC: begin
				state_d = exe_done ? vdts_pkg::ST_RELEASE : vdts_pkg::ST_FINISH;
			end
			vdts_pkg::ST_RELEASE: begin
				state_d = vdts_pkg::ST_FINISH;
			end
			vdts_pkg::ST_FINISH: begin
				if (out_load) state_d = vdts_pkg::ST_IDLE;
			end
			default: state_d = vdts_pkg::ST_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vdts_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control state: slot flags, scan counters, tick counter, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			pending_q    <= '0;
			tick_count_q <= '0;
			idx_q        <= '0;
			found_q      <= 1'b0;
			finished_q   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (load_now) begin
				valid_q[req.slot]   <= 1'b1;
				pending_q[req.slot] <= 1'b1;
			end
			if (tick_start) begin
				idx_q      <= '0;
				found_q    <= 1'b0;
				finished_q <= 1'b0;
			end
			if (state_q == vdts_pkg::ST_SCAN_A) begin
				pending_q[idx_q] <= eff_pend;
				if (eff_pend) found_q <= 1'b1;
				if (!(eff_pend && found_q)) idx_q <= idx_q + SW'(1);
			end
			if (state_q == vdts_pkg::ST_SCAN_B) idx_q <= idx_q + SW'(1);
			if ((state_q == vdts_pkg::ST_EXEC) && exe_done) begin
				finished_q        <= 1'b1;
				pending_q[best_q] <= 1'b0;
			end
			if (out_load) begin
				out_valid_q  <= 1'b1;
				tick_count_q <= tick_count_q + TW'(1);
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Table payload and scan datapath.
	always_ff @(posedge clk) begin
		if (load_now) begin
			period_q[req.slot]   <= req.task_period;
			capacity_q[req.slot] <= req.task_capacity;
			value_q[req.slot]    <= req.task_value;
			executed_q[req.slot] <= '0;
			jobs_q[req.slot]     <= '0;
			release_q[req.slot]  <= {16'd0, req.task_period};
		end
		// First pending slot becomes the candidate; later ones compute the lhs product.
		if ((state_q == vdts_pkg::ST_SCAN_A) && eff_pend) begin
			if (!found_q) begin
				best_q     <= idx_q;
				best_val_q <= value_q[idx_q];
				best_cap_q <= capacity_q[idx_q];
			end else begin
				prod_q <= mul_p;
			end
		end
		// Strictly greater density replaces the candidate, so ties keep the lower slot.
		if ((state_q == vdts_pkg::ST_SCAN_B) && (prod_q > mul_p)) begin
			best_q     <= idx_q;
			best_val_q <= value_q[idx_q];
			best_cap_q <= capacity_q[idx_q];
		end
		if (state_q == vdts_pkg::ST_EXEC) begin
			if (exe_done) begin
				executed_q[best_q] <= '0;
				jobs_q[best_q]     <= jobs_q[best_q] + FW'(1);
			end else begin
				executed_q[best_q] <= exe_inc;
			end
		end
		if (state_q == vdts_pkg::ST_RELEASE) release_q[best_q] <= mul_p;
		if (out_load) begin
			out_slot_q <= found_q ? {1'b0, best_q} : vdts_pkg::IDLE_SLOT;
			out_idle_q <= !found_q;
			out_fin_q  <= finished_q;
			out_tick_q <= tick_count_q;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.running_slot = out_slot_q;
	assign rsp.idle         = out_idle_q;
	assign rsp.job_finished = out_fin_q;
	assign rsp.tick_now     = out_tick_q;

	// The idle flag agrees with the reported slot code.
	a_idle_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.idle == (rsp.running_slot == vdts_pkg::IDLE_SLOT)))
		else $error("idle flag disagrees with running slot");

	// A finished job implies a task actually ran.
	a_fin_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.job_finished) |-> !rsp.idle)
		else $error("job finished on an idle tick");

	// The tick counter advances exactly once per delivered decision.
	a_tick_adv: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (tick_count_q == $past(tick_count_q) + TW'(1)))
		else $error("tick counter did not advance");

	// A load transaction never starts a scan.
	a_load_stay: assert property (@(posedge clk) disable iff (!arst_n)
		load_now |=> (state_q == vdts_pkg::ST_IDLE))
		else $error("load transaction left the idle state");

endmodule

/* tb/sv/tb_value_density_task_scheduler_core.sv */
// ----------------------------------------------------------------------------
// tb_value_density_task_scheduler_core: self-checking scheduler testbench
// Drives load and tick transactions into the scheduler with bursty traffic and
// a stalling receiver. It predicts every scheduling decision from its own copy
// of the task table and compares each result field by field, in order.
// ----------------------------------------------------------------------------
module tb_value_density_task_scheduler_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_TASKS = vdts_pkg::NUM_TASKS;
	localparam int SLOT_W    = vdts_pkg::SLOT_W;
	localparam int RSLOT_W   = vdts_pkg::RSLOT_W;
	localparam int FIELD_W   = vdts_pkg::FIELD_W;
	localparam int TICK_W    = vdts_pkg::TICK_W;

	// One input transaction as the testbench sees it.
	typedef struct {
		logic               kind;
		logic [SLOT_W-1:0]  slot;
		logic [FIELD_W-1:0] period;
		logic [FIELD_W-1:0] capacity;
		logic [FIELD_W-1:0] value;
	} task_item_t;

	// One scheduling decision.
	typedef struct {
		logic [RSLOT_W-1:0] running_slot;
		logic               idle;
		logic               job_finished;
		logic [TICK_W-1:0]  tick_now;
	} decision_t;

	logic clk;
	logic arst_n;

	vdts_req_if req_ch ();
	vdts_rsp_if rsp_ch ();

	value_density_task_scheduler_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow copy of the task table.
	bit                 slot_live   [NUM_TASKS];
	bit                 job_ready   [NUM_TASKS];
	logic [FIELD_W-1:0] period_tab  [NUM_TASKS];
	logic [FIELD_W-1:0] cap_tab     [NUM_TASKS];
	logic [FIELD_W-1:0] value_tab   [NUM_TASKS];
	logic [FIELD_W-1:0] ran_ticks   [NUM_TASKS];
	logic [FIELD_W-1:0] jobs_closed [NUM_TASKS];
	logic [TICK_W-1:0]  release_at  [NUM_TASKS];
	logic [TICK_W-1:0]  ticks_seen;

	decision_t expected_decisions[$];
	int        mismatches;
	int        burst_left;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Overall time limit.
	initial begin
		#1500000;
		$display("FAIL");
		$finish;
	end

	// Apply one accepted transaction to the shadow table and queue the decision.
	function automatic void predict_schedule(input task_item_t it);
		int          best;
		logic [31:0] lhs;
		logic [31:0] rhs;
		decision_t   d;

		best = -1;
		if (it.kind == vdts_pkg::KIND_LOAD) begin
			period_tab[it.slot]  = it.period;
			cap_tab[it.slot]     = it.capacity;
			value_tab[it.slot]   = it.value;
			ran_ticks[it.slot]   = '0;
			jobs_closed[it.slot] = '0;
			release_at[it.slot]  = {16'd0, it.period};
			job_ready[it.slot]   = 1'b1;
			slot_live[it.slot]   = 1'b1;
			return;
		end

		// Release every task whose next release falls on this tick.
		for (int i = 0; i < NUM_TASKS; i++) begin
			if (slot_live[i] && release_at[i] == ticks_seen)
				job_ready[i] = 1'b1;
		end

		// Pick the greatest density; a tie keeps the lower slot.
		for (int i = 0; i < NUM_TASKS; i++) begin
			if (slot_live[i] && job_ready[i]) begin
				if (best < 0) begin
					best = i;
				end else begin
					lhs = value_tab[i] * cap_tab[best];
					rhs = value_tab[best] * cap_tab[i];
					if (lhs > rhs)
						best = i;
				end
			end
		end

		d.job_finished = 1'b0;
		d.tick_now     = ticks_seen;
		if (best >= 0) begin
			ran_ticks[best] = ran_ticks[best] + 16'd1;
			if (ran_ticks[best] >= cap_tab[best]) begin
				d.job_finished    = 1'b1;
				ran_ticks[best]   = '0;
				job_ready[best]   = 1'b0;
				jobs_closed[best] = jobs_closed[best] + 16'd1;
				release_at[best]  = period_tab[best] * jobs_closed[best];
			end
			d.running_slot = RSLOT_W'(best);
			d.idle         = 1'b0;
		end else begin
			d.running_slot = vdts_pkg::IDLE_SLOT;
			d.idle         = 1'b1;
		end
		ticks_seen = ticks_seen + 32'd1;
		expected_decisions.push_back(d);
	endfunction

	function automatic task_item_t load_item(input int slot, input int period,
			input int capacity, input int value);
		task_item_t it;

		it.kind     = vdts_pkg::KIND_LOAD;
		it.slot     = SLOT_W'(slot);
		it.period   = FIELD_W'(period);
		it.capacity = FIELD_W'(capacity);
		it.value    = FIELD_W'(value);
		return it;
	endfunction

	// A tick carries random content in the fields that it ignores.
	function automatic task_item_t tick_item();
		task_item_t it;

		it.kind     = vdts_pkg::KIND_TICK;
		it.slot     = SLOT_W'($urandom);
		it.period   = FIELD_W'($urandom);
		it.capacity = FIELD_W'($urandom);
		it.value    = FIELD_W'($urandom);
		return it;
	endfunction

	// Send one transaction; called at a falling edge and returns at one.
	// The sender works in bursts with random gaps between them.
	task automatic send_item(input task_item_t it);
		int gap;

		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		req_ch.kind          <= it.kind;
		req_ch.slot          <= it.slot;
		req_ch.task_period   <= it.period;
		req_ch.task_capacity <= it.capacity;
		req_ch.task_value    <= it.value;
		req_ch.valid         <= 1'b1;
		do @(posedge clk); while (!req_ch.ready);
		predict_schedule(it);
		@(negedge clk);
	endtask

	task automatic send_ticks(input int n);
		repeat (n) send_item(tick_item());
	endtask

	// Hold the sender off until every queued decision has come back.
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		@(negedge clk);
		while (expected_decisions.size() != 0)
			@(negedge clk);
	endtask

	// Ticks on an empty table report idle.
	task automatic test_idle_ticks();
		send_ticks(2);
	endtask

	// A period-three task with unit capacity is released on each multiple of three.
	task automatic test_periodic_release();
		send_item(load_item(1, 3, 1, 65535));
		send_ticks(5);
		// Park the slot with zero value and a far release.
		send_item(load_item(1, 65535, 1, 0));
	endtask

	// Extreme field values, including the widest cross products.
	task automatic test_field_extremes();
		send_item(load_item(0, 65535, 1, 65535));
		send_item(load_item(7, 1, 65535, 0));
		send_item(load_item(6, 65535, 65535, 65535));
		send_ticks(2);
	endtask

	// Equal densities: the lower slot wins.
	task automatic test_density_tie();
		send_item(load_item(5, 60000, 3, 60000));
		send_item(load_item(3, 60000, 2, 40000));
		send_ticks(3);
	endtask

	// Reloading a slot in the middle of a job restarts it as a fresh task.
	task automatic test_reload_mid_job();
		send_item(load_item(2, 3, 3, 65000));
		send_ticks(1);
		send_item(load_item(2, 2, 2, 65000));
		send_ticks(2);
	endtask

	// Random traffic: mostly ticks over small, short-period tasks, with some
	// full-range loads mixed in.
	task automatic test_random_traffic(input int n);
		int         r;
		int         period;
		task_item_t it;

		for (int k = 0; k < n; k++) begin
			if (k == n / 2)
				drain_results();
			if ($urandom_range(0, 99) >= 18) begin
				send_item(tick_item());
				continue;
			end
			r = $urandom_range(0, 9);
			it = load_item($urandom_range(0, NUM_TASKS - 1), 1, 1, 0);
			if (r < 6) begin
				if ($urandom_range(0, 1) == 0)
					period = $urandom_range(1, 24);
				else
					period = int'(ticks_seen) + $urandom_range(1, 40);
				it.period   = (period > 65535) ? 16'hFFFF : FIELD_W'(period);
				it.capacity = FIELD_W'($urandom_range(1, 6));
				it.value    = ($urandom_range(0, 2) == 0) ? FIELD_W'($urandom_range(0, 8))
					: FIELD_W'($urandom);
			end else if (r < 9) begin
				it.period   = FIELD_W'($urandom_range(1, 65535));
				it.capacity = FIELD_W'($urandom_range(1, 65535));
				it.value    = FIELD_W'($urandom);
			end else begin
				it.period   = $urandom_range(0, 1) ? 16'hFFFF : 16'd1;
				it.capacity = $urandom_range(0, 1) ? 16'hFFFF : 16'd1;
				it.value    = $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
			end
			send_item(it);
		end
	endtask

	// The receiver switches between always ready, random stalls and long stalls.
	initial begin
		int   mode;
		int   mode_left;
		int   hold;
		logic level;

		mode_left = 0;
		hold      = 0;
		level     = 1'b1;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (mode_left == 0) begin
				mode      = $urandom_range(0, 2);
				mode_left = $urandom_range(50, 300);
			end
			mode_left--;
			case (mode)
				0: begin
					rsp_ch.ready <= 1'b1;
				end
				1: begin
					rsp_ch.ready <= ($urandom_range(0, 3) != 0);
				end
				default: begin
					if (hold == 0) begin
						level = ~level;
						hold  = level ? $urandom_range(1, 4) : $urandom_range(1, 15);
					end
					hold--;
					rsp_ch.ready <= level;
				end
			endcase
		end
	end

	task automatic check_field(input string name, input longint expected,
			input longint actual);
		if (expected != actual) begin
			mismatches++;
			$display("%0t ns: %s mismatch, expected %0d, actual %0d",
				$time, name, expected, actual);
		end
	endtask

	// Compare each result transaction against the oldest queued decision.
	always @(posedge clk) begin
		decision_t d;

		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_decisions.size() == 0) begin
				mismatches++;
				$display("%0t ns: result with none expected, running_slot %0d tick_now %0d",
					$time, rsp_ch.running_slot, rsp_ch.tick_now);
			end else begin
				d = expected_decisions.pop_front();
				check_field("running_slot", d.running_slot, rsp_ch.running_slot);
				check_field("idle", d.idle, rsp_ch.idle);
				check_field("job_finished", d.job_finished, rsp_ch.job_finished);
				check_field("tick_now", d.tick_now, rsp_ch.tick_now);
			end
		end
	end

	// Main sequence.
	initial begin
		arst_n               = 1'b0;
		req_ch.valid         = 1'b0;
		req_ch.kind          = vdts_pkg::KIND_LOAD;
		req_ch.slot          = '0;
		req_ch.task_period   = '0;
		req_ch.task_capacity = '0;
		req_ch.task_value    = '0;
		mismatches           = 0;
		burst_left           = 0;
		ticks_seen           = '0;
		for (int i = 0; i < NUM_TASKS; i++) begin
			slot_live[i] = 1'b0;
			job_ready[i] = 1'b0;
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_idle_ticks();
		test_periodic_release();
		test_field_extremes();
		test_density_tie();
		test_reload_mid_job();
		drain_results();
		test_random_traffic(1600);

		// Let the last decisions come back, then allow for a late extra result.
		req_ch.valid <= 1'b0;
		while (expected_decisions.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (mismatches == 0 && expected_decisions.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

/* filelist.f */
src/vdts_pkg.sv
src/vdts_if.sv
src/value_density_task_scheduler_core.sv
tb/sv/tb_value_density_task_scheduler_core.sv
